>>> sv/rap_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ring all-reduce chunk planner.
// No dependencies.
package rap_pkg;

    localparam int DATA_W  = 32;
    localparam int LEN_W   = 32;
    localparam int OFF_W   = 35;
    localparam int ADDR_W  = 4;
    localparam int CHUNK_ALIGN = 8;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_RING_SIZE     = 2'd0;
    localparam logic [1:0] REG_OWN_RANK      = 2'd1;
    localparam logic [1:0] REG_ELEMENT_COUNT = 2'd2;
    localparam logic [1:0] REG_ELEMENT_BYTES = 2'd3;

    // lengths derived from configuration, used by the step pipeline
    typedef struct packed {
        logic [LEN_W-1:0] chunk_len;     // elements per regular chunk
        logic [LEN_W-1:0] last_len;      // elements in the last chunk
        logic [OFF_W-1:0] chunk_bytes;   // element_bytes * chunk_len
        logic [OFF_W-1:0] last_bytes;    // element_bytes * last_len
    } lens_t;

endpackage

>>> sv/rap_cfg.sv
`timescale 1ns / 1ps
// APB register file plus the sequencer that derives chunk lengths.
// Depends on rap_pkg.
module rap_cfg #(
    parameter int MAX_RANKS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rap_pkg::ADDR_W-1:0]   paddr,
    input  logic [rap_pkg::DATA_W-1:0]   pwdata,
    output logic [rap_pkg::DATA_W-1:0]   prdata,
    output logic                         hold,
    output logic [$clog2(MAX_RANKS+1)-1:0] r_eff,
    output logic [$clog2(MAX_RANKS+1)-1:0] rank_eff,
    output rap_pkg::lens_t               lens
);

    localparam int RW = $clog2(MAX_RANKS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_LAST  = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;

    logic [6:0]  ring_size_reg;
    logic [5:0]  own_rank_reg;
    logic [31:0] element_count_reg;
    logic [3:0]  element_bytes_reg;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [RW-1:0] rem_reg;
    logic [5:0]  rank_sh_reg;
    logic [RW-1:0] rank_rem_reg;
    logic [RW-1:0] r_eff_reg;
    logic [3:0]  eb_reg;
    logic [31:0] chunk_reg;
    logic [31:0] last_reg;
    logic [31:0] prod_reg;
    logic [34:0] chunk_bytes_reg;
    logic [34:0] last_bytes_reg;

    logic          wr;
    logic [1:0]    idx;
    logic [RW-1:0] ring_clamp;
    logic [3:0]    eb_clamp;
    logic [RW:0]   trial, rtrial;
    logic          ge, rge;
    logic [RW:0]   diff, rdiff;
    logic [31:0]   prod_full;
    logic [35:0]   cb_full, lb_full;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_comb
    begin
        if (ring_size_reg < 7'd2)
            ring_clamp = RW'(2);
        else if (32'(ring_size_reg) > MAX_RANKS)
            ring_clamp = RW'(MAX_RANKS);
        else
            ring_clamp = RW'(ring_size_reg);
    end

    always_comb
    begin
        if (element_bytes_reg == 4'd0)
            eb_clamp = 4'd1;
        else if (element_bytes_reg > 4'd8)
            eb_clamp = 4'd8;
        else
            eb_clamp = element_bytes_reg;
    end

    // one restoring-division bit per cycle, rank remainder alongside
    assign trial  = {rem_reg, quo_reg[31]};
    assign ge     = trial >= {1'b0, r_eff_reg};
    assign diff   = trial - {1'b0, r_eff_reg};
    assign rtrial = {rank_rem_reg, rank_sh_reg[5]};
    assign rge    = rtrial >= {1'b0, r_eff_reg};
    assign rdiff  = rtrial - {1'b0, r_eff_reg};

    // only the low 32 bits of chunk * (R-1) matter for the remainder
    assign prod_full = chunk_reg * 32'(r_eff_reg - RW'(1));
    assign cb_full   = {32'd0, eb_reg} * {4'd0, chunk_reg};
    assign lb_full   = {32'd0, eb_reg} * {4'd0, last_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   state_next = (cnt_reg == 5'd31) ? ST_ALIGN : ST_DIV;
            ST_ALIGN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_LAST;
            ST_LAST:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        if (wr)
            state_next = ST_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg     <= 7'd2;
            own_rank_reg      <= 6'd0;
            element_count_reg <= 32'd0;
            element_bytes_reg <= 4'd4;
            state_reg         <= ST_IDLE;
            cnt_reg           <= 5'd0;
            r_eff_reg         <= RW'(2);
            rank_rem_reg      <= '0;
            eb_reg            <= 4'd4;
            chunk_reg         <= 32'd0;
            last_reg          <= 32'd0;
            chunk_bytes_reg   <= 35'd0;
            last_bytes_reg    <= 35'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                case (idx)
                    rap_pkg::REG_RING_SIZE:     ring_size_reg     <= pwdata[6:0];
                    rap_pkg::REG_OWN_RANK:      own_rank_reg      <= pwdata[5:0];
                    rap_pkg::REG_ELEMENT_COUNT: element_count_reg <= pwdata;
                    rap_pkg::REG_ELEMENT_BYTES: element_bytes_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_LOAD:
                begin
                    r_eff_reg    <= ring_clamp;
                    eb_reg       <= eb_clamp;
                    rank_rem_reg <= '0;
                    cnt_reg      <= 5'd0;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg < 5'd6)
                        rank_rem_reg <= rge ? rdiff[RW-1:0] : rtrial[RW-1:0];
                end
                ST_ALIGN:
                    chunk_reg <= (quo_reg >= 32'(rap_pkg::CHUNK_ALIGN))
                               ? {quo_reg[31:3], 3'b000} : quo_reg;
                ST_MUL:
                    chunk_bytes_reg <= cb_full[34:0];
                ST_LAST:
                    last_reg <= element_count_reg - prod_reg;
                ST_SCALE:
                    last_bytes_reg <= lb_full[34:0];
                default: ;
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                quo_reg     <= element_count_reg;
                rem_reg     <= '0;
                rank_sh_reg <= own_rank_reg;
            end
            ST_DIV:
            begin
                quo_reg     <= {quo_reg[30:0], ge};
                rem_reg     <= ge ? diff[RW-1:0] : trial[RW-1:0];
                rank_sh_reg <= {rank_sh_reg[4:0], 1'b0};
            end
            ST_MUL:
                prod_reg <= prod_full;
            default: ;
        endcase
    end

    always_comb
    begin
        case (idx)
            rap_pkg::REG_RING_SIZE:     prdata = {25'd0, ring_size_reg};
            rap_pkg::REG_OWN_RANK:      prdata = {26'd0, own_rank_reg};
            rap_pkg::REG_ELEMENT_COUNT: prdata = element_count_reg;
            rap_pkg::REG_ELEMENT_BYTES: prdata = {28'd0, element_bytes_reg};
            default:                    prdata = '0;
        endcase
    end

    assign hold     = wr || (state_reg != ST_IDLE);
    assign r_eff    = r_eff_reg;
    assign rank_eff = rank_rem_reg;
    assign lens.chunk_len   = chunk_reg;
    assign lens.last_len    = last_reg;
    assign lens.chunk_bytes = chunk_bytes_reg;
    assign lens.last_bytes  = last_bytes_reg;

endmodule

>>> sv/rap_pipe.sv
`timescale 1ns / 1ps
// Four-stage step pipeline: phase and chunk indices, offsets, sizes.
// Depends on rap_pkg.
module rap_pipe #(
    parameter int MAX_RANKS    = 64,
    parameter int INLINE_BYTES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            hold,
    input  logic [$clog2(MAX_RANKS+1)-1:0]  r_eff,
    input  logic [$clog2(MAX_RANKS+1)-1:0]  rank_eff,
    input  rap_pkg::lens_t                  lens,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [6:0]                      step,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            bad_step,
    output logic [5:0]                      send_chunk,
    output logic                            send_from_source,
    output logic [34:0]                     send_byte_offset,
    output logic [34:0]                     send_byte_count,
    output logic                            send_inline,
    output logic [5:0]                      recv_chunk,
    output logic                            recv_into_result,
    output logic [34:0]                     recv_byte_offset,
    output logic                            reduce_active,
    output logic [31:0]                     reduce_element_count
);

    localparam int RW = $clog2(MAX_RANKS + 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic          s1_bad_reg, s1_red_reg, s1_first_reg;
    logic [RW:0]   s1_d_reg;
    // stage 2
    logic          s2_bad_reg, s2_red_reg, s2_first_reg;
    logic          s2_snd_last_reg, s2_rcv_last_reg;
    logic [RW-1:0] s2_snd_reg, s2_rcv_reg;
    // stage 3
    logic          s3_bad_reg, s3_red_reg, s3_first_reg, s3_rcv_last_reg;
    logic [RW-1:0] s3_snd_reg, s3_rcv_reg;
    logic [34:0]   s3_soff_reg, s3_sbytes_reg;
    // stage 4 (output)
    logic          o_bad_reg, o_first_reg, o_inline_reg, o_red_reg;
    logic [5:0]    o_snd_reg, o_rcv_reg;
    logic [34:0]   o_soff_reg, o_sbytes_reg, o_roff_reg;
    logic [31:0]   o_rcnt_reg;

    logic [31:0]    s32, r32, t32, d32;
    logic [RW:0]    snd_w;
    logic [RW-1:0]  snd_c, rcv_c, rm1;
    logic [RW+34:0] soff_full, roff_full;
    logic [34:0]    roff_c;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1 && !hold;

    // stage 1: phase, bad flag, step folded into one ring turn
    assign s32 = 32'(step);
    assign r32 = 32'(r_eff);
    assign t32 = (s32 >= r32) ? s32 - r32 : s32;
    assign d32 = 32'(rank_eff) + r32 - t32;

    // stage 2: chunk indices
    assign rm1   = r_eff - RW'(1);
    assign snd_w = (s1_d_reg >= {1'b0, r_eff}) ? s1_d_reg - {1'b0, r_eff} : s1_d_reg;
    assign snd_c = snd_w[RW-1:0];
    assign rcv_c = (snd_c == '0) ? rm1 : snd_c - RW'(1);

    // stages 3 and 4: byte offsets
    assign soff_full = {35'd0, s2_snd_reg} * {{RW{1'b0}}, lens.chunk_bytes};
    assign roff_full = {35'd0, s3_rcv_reg} * {{RW{1'b0}}, lens.chunk_bytes};
    assign roff_c    = roff_full[34:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid && in_ready;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid && in_ready)
        begin
            s1_bad_reg   <= s32 >= 2 * r32 - 32'd2;
            s1_red_reg   <= s32 < r32 - 32'd1;
            s1_first_reg <= step == 7'd0;
            s1_d_reg     <= d32[RW:0];
        end
        if (rdy2 && v1_reg)
        begin
            s2_bad_reg      <= s1_bad_reg;
            s2_red_reg      <= s1_red_reg;
            s2_first_reg    <= s1_first_reg;
            s2_snd_reg      <= snd_c;
            s2_rcv_reg      <= rcv_c;
            s2_snd_last_reg <= snd_c == rm1;
            s2_rcv_last_reg <= rcv_c == rm1;
        end
        if (rdy3 && v2_reg)
        begin
            s3_bad_reg      <= s2_bad_reg;
            s3_red_reg      <= s2_red_reg;
            s3_first_reg    <= s2_first_reg;
            s3_rcv_last_reg <= s2_rcv_last_reg;
            s3_snd_reg      <= s2_snd_reg;
            s3_rcv_reg      <= s2_rcv_reg;
            s3_soff_reg     <= soff_full[34:0];
            s3_sbytes_reg   <= s2_snd_last_reg ? lens.last_bytes : lens.chunk_bytes;
        end
        if (rdy4 && v3_reg)
        begin
            // an out-of-range step clears every field but the flag
            o_bad_reg    <= s3_bad_reg;
            o_first_reg  <= !s3_bad_reg && s3_first_reg;
            o_red_reg    <= !s3_bad_reg && s3_red_reg;
            o_snd_reg    <= s3_bad_reg ? 6'd0 : 6'(s3_snd_reg);
            o_rcv_reg    <= s3_bad_reg ? 6'd0 : 6'(s3_rcv_reg);
            o_soff_reg   <= s3_bad_reg ? 35'd0 : s3_soff_reg;
            o_sbytes_reg <= s3_bad_reg ? 35'd0 : s3_sbytes_reg;
            o_roff_reg   <= s3_bad_reg ? 35'd0 : roff_c;
            o_inline_reg <= !s3_bad_reg && (s3_sbytes_reg <= 35'(INLINE_BYTES));
            if (s3_bad_reg || !s3_red_reg)
                o_rcnt_reg <= 32'd0;
            else
                o_rcnt_reg <= s3_rcv_last_reg ? lens.last_len : lens.chunk_len;
        end
    end

    assign out_valid            = v4_reg;
    assign bad_step             = o_bad_reg;
    assign send_chunk           = o_snd_reg;
    assign send_from_source     = o_first_reg;
    assign send_byte_offset     = o_soff_reg;
    assign send_byte_count      = o_sbytes_reg;
    assign send_inline          = o_inline_reg;
    assign recv_chunk           = o_rcv_reg;
    assign recv_into_result     = !o_bad_reg && !o_red_reg;
    assign recv_byte_offset     = o_roff_reg;
    assign reduce_active        = o_red_reg;
    assign reduce_element_count = o_rcnt_reg;

endmodule

>>> sv/ring_allreduce_chunk_planner_unit.sv
`timescale 1ns / 1ps
// Top level of the ring all-reduce chunk planner; depends on rap_pkg, rap_cfg, rap_pipe.
// A plan leaves the step pipeline once it has passed the S1 to S4 registers. Requests
// are taken one per cycle sustained while out_ready is high and hold is low.
// After reset the derived lengths come up as zero, matching the reset registers.
// A register write reruns the length sequencer: load, a divider step per quotient bit,
// align, multiply, last, scale; in_ready is low in the access cycle and while it runs.
module ring_allreduce_chunk_planner_unit #(
    parameter int MAX_RANKS    = 64,
    parameter int INLINE_BYTES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rap_pkg::ADDR_W-1:0]  paddr,
    input  logic [rap_pkg::DATA_W-1:0]  pwdata,
    output logic [rap_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // step requests
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [6:0]                  step,
    // plan results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        bad_step,
    output logic [5:0]                  send_chunk,
    output logic                        send_from_source,
    output logic [34:0]                 send_byte_offset,
    output logic [34:0]                 send_byte_count,
    output logic                        send_inline,
    output logic [5:0]                  recv_chunk,
    output logic                        recv_into_result,
    output logic [34:0]                 recv_byte_offset,
    output logic                        reduce_active,
    output logic [31:0]                 reduce_element_count
);

    localparam int RW = $clog2(MAX_RANKS + 1);

    logic           hold;       // sequencer busy or write in progress: no new request
    logic [RW-1:0]  r_eff;      // ring size clamped to 2..MAX_RANKS
    logic [RW-1:0]  rank_eff;   // own rank mod ring size
    rap_pkg::lens_t lens;

    // zero-wait APB slave
    assign pready = 1'b1;

    // Config registers and the derived chunk lengths. The quotient of
    // element_count by the ring size comes from a restoring divider, one
    // bit per cycle; the own-rank remainder runs in the same pass.
    rap_cfg #(
        .MAX_RANKS (MAX_RANKS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .hold     (hold),
        .r_eff    (r_eff),
        .rank_eff (rank_eff),
        .lens     (lens)
    );

    // Step pipeline:
    //   S1 phase / range check, step folded into one ring turn
    //   S2 send and receive chunk indices
    //   S3 send offset multiply, send size select
    //   S4 receive offset multiply, inline check, output register
    rap_pipe #(
        .MAX_RANKS    (MAX_RANKS),
        .INLINE_BYTES (INLINE_BYTES)
    ) u_pipe (
        .clk                  (clk),
        .rst_n                (rst_n),
        .hold                 (hold),
        .r_eff                (r_eff),
        .rank_eff             (rank_eff),
        .lens                 (lens),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .step                 (step),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .bad_step             (bad_step),
        .send_chunk           (send_chunk),
        .send_from_source     (send_from_source),
        .send_byte_offset     (send_byte_offset),
        .send_byte_count      (send_byte_count),
        .send_inline          (send_inline),
        .recv_chunk           (recv_chunk),
        .recv_into_result     (recv_into_result),
        .recv_byte_offset     (recv_byte_offset),
        .reduce_active        (reduce_active),
        .reduce_element_count (reduce_element_count)
    );

`ifndef NO_ASSERTIONS
    // no request enters while lengths are being recomputed
    a_no_take_while_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !hold)
        else $error("request accepted while config sequencer busy");

    // out-of-range step carries only the flag
    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_step |-> send_byte_count == 35'd0 && send_byte_offset == 35'd0
            && recv_byte_offset == 35'd0 && reduce_element_count == 32'd0
            && !send_inline && !reduce_active && !recv_into_result)
        else $error("bad step result has nonzero fields");

    // every valid step is in exactly one phase
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_step |-> reduce_active != recv_into_result)
        else $error("reduce and gather phase both or neither");

    // gather phase reduces nothing
    a_gather_no_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reduce_active |-> reduce_element_count == 32'd0)
        else $error("reduce count outside reduce phase");

    // step 0 always lies in the reduce phase
    a_first_is_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_from_source |-> reduce_active && !bad_step)
        else $error("source-buffer send outside first reduce step");
`endif

endmodule

>>> bench/tb_ring_allreduce_chunk_planner_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the ring all-reduce chunk planner: step requests in, plans out.
// Depends on rap_pkg and ring_allreduce_chunk_planner_unit.
module tb_ring_allreduce_chunk_planner_unit;

    localparam int PLAN_MAX_RANKS = 64;
    localparam int INLINE_LIMIT   = 256;
    localparam int LONG_HOLD      = 200;    // receiver stall long enough to back up the pipe
    localparam int STALL_LIMIT    = 3000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES    = 8;      // pipe is 4 deep; catch anything stray
    localparam longint unsigned OFF_MASK = (64'd1 << rap_pkg::OFF_W) - 64'd1;

    // one plan as the block should report it
    typedef struct packed {
        logic        bad_step;
        logic [5:0]  send_chunk;
        logic        send_from_source;
        logic [34:0] send_byte_offset;
        logic [34:0] send_byte_count;
        logic        send_inline;
        logic [5:0]  recv_chunk;
        logic        recv_into_result;
        logic [34:0] recv_byte_offset;
        logic        reduce_active;
        logic [31:0] reduce_element_count;
    } step_plan_t;

    // ---------------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [rap_pkg::ADDR_W-1:0] paddr = '0;
    logic [rap_pkg::DATA_W-1:0] pwdata = '0;
    logic [rap_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [6:0]                 step = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       bad_step;
    logic [5:0]                 send_chunk;
    logic                       send_from_source;
    logic [34:0]                send_byte_offset;
    logic [34:0]                send_byte_count;
    logic                       send_inline;
    logic [5:0]                 recv_chunk;
    logic                       recv_into_result;
    logic [34:0]                recv_byte_offset;
    logic                       reduce_active;
    logic [31:0]                reduce_element_count;

    ring_allreduce_chunk_planner_unit #(
        .MAX_RANKS    (PLAN_MAX_RANKS),
        .INLINE_BYTES (INLINE_LIMIT)
    ) uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .step                 (step),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .bad_step             (bad_step),
        .send_chunk           (send_chunk),
        .send_from_source     (send_from_source),
        .send_byte_offset     (send_byte_offset),
        .send_byte_count      (send_byte_count),
        .send_inline          (send_inline),
        .recv_chunk           (recv_chunk),
        .recv_into_result     (recv_into_result),
        .recv_byte_offset     (recv_byte_offset),
        .reduce_active        (reduce_active),
        .reduce_element_count (reduce_element_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------------------
    // Planner model: register copies plus the two derived lengths
    // ---------------------------------------------------------------------------------
    logic [6:0]  cfg_ring  = 7'd2;
    logic [5:0]  cfg_rank  = 6'd0;
    logic [31:0] cfg_count = 32'd0;
    logic [3:0]  cfg_bytes = 4'd4;
    logic [31:0] chunk_len = 32'd0;
    logic [31:0] last_len  = 32'd0;

    // ring size clamped to 2..MAX_RANKS
    function automatic longint unsigned ring_eff();
        longint unsigned r;
        r = 64'(cfg_ring);
        if (r < 2) r = 2;
        if (r > PLAN_MAX_RANKS) r = PLAN_MAX_RANKS;
        return r;
    endfunction

    // element size: 0 acts as 1, anything above 8 acts as 8
    function automatic longint unsigned bytes_eff();
        longint unsigned b;
        b = 64'(cfg_bytes);
        if (b < 1) b = 1;
        if (b > 8) b = 8;
        return b;
    endfunction

    // chunk length = count / R, aligned down to 8 once it reaches 8; last chunk gets the rest
    function automatic void derive_chunk_lengths();
        longint unsigned r, q, rest;
        r = ring_eff();
        q = 64'(cfg_count) / r;
        if (q >= rap_pkg::CHUNK_ALIGN) q = q - (q % rap_pkg::CHUNK_ALIGN);
        rest = 64'(cfg_count) - q * (r - 1);
        chunk_len = q[31:0];
        last_len  = rest[31:0];
    endfunction

    function automatic longint unsigned length_of_chunk(input longint unsigned idx,
                                                        input longint unsigned r);
        return (idx == r - 1) ? 64'(last_len) : 64'(chunk_len);
    endfunction

    // expected plan for one step request under the current configuration
    function automatic step_plan_t plan_step(input logic [6:0] s);
        step_plan_t      p;
        longint unsigned r, rank, eb, t, snd, rcv, sbytes;
        bit              reduce;
        p = '0;
        r = ring_eff();
        rank = 64'(cfg_rank) % r;
        eb = bytes_eff();
        // out-of-range step: flag only, all else zero
        if (s >= 2 * r - 2)
        begin
            p.bad_step = 1'b1;
            return p;
        end
        reduce = (s < r - 1);
        t = s % r;
        snd = (rank + r - t) % r;
        rcv = (rank + 2 * r - t - 1) % r;
        sbytes = (eb * length_of_chunk(snd, r)) & OFF_MASK;
        p.send_chunk           = snd[5:0];
        p.send_from_source     = (s == 7'd0);
        p.send_byte_offset     = 35'((eb * snd * chunk_len) & OFF_MASK);
        p.send_byte_count      = sbytes[34:0];
        p.send_inline          = (sbytes <= INLINE_LIMIT);
        p.recv_chunk           = rcv[5:0];
        p.recv_into_result     = !reduce;
        p.recv_byte_offset     = 35'((eb * rcv * chunk_len) & OFF_MASK);
        p.reduce_active        = reduce;
        p.reduce_element_count = reduce ? 32'(length_of_chunk(rcv, r)) : 32'd0;
        return p;
    endfunction

    // ---------------------------------------------------------------------------------
    // Shared bookkeeping
    // ---------------------------------------------------------------------------------
    logic [6:0] step_q[$];          // requests waiting for the driver
    step_plan_t plans_due[$];       // plans predicted at request accept, oldest first
    int         steps_queued  = 0;
    int         plans_checked = 0;
    int         errors        = 0;
    int         tx_wait       = 0;
    int         rx_wait       = 0;
    int         hold_left     = 0;
    int         holds_asked   = 0;
    int         holds_done    = 0;
    bit         tx_idle_on    = 1'b0;
    bit         rx_idle_on    = 1'b0;
    int         idle_cycles   = 0;

    function automatic int draw_wait(input bit on);
        return on ? int'($urandom_range(0, 16)) : 0;
    endfunction

    // ---------------------------------------------------------------------------------
    // Request driver: one NBA per signal per edge, so valid stays up across
    // back-to-back requests. The plan is predicted the moment a request is taken.
    // ---------------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            step     <= '0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                plans_due.push_back(plan_step(step));
                tx_wait = draw_wait(tx_idle_on);
            end
            // payload may only move when nothing is being offered or it was just taken
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (step_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    step     <= step_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Plan monitor and receiver backpressure
    // ---------------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_plan();
        step_plan_t want;
        if (plans_due.size() == 0)
        begin
            errors++;
            $display("%0t: plan with no request outstanding, expected none, actual bad_step=%0b",
                     $time, bad_step);
            return;
        end
        want = plans_due.pop_front();
        check_field("bad_step",             64'(want.bad_step),         64'(bad_step));
        check_field("send_chunk",           64'(want.send_chunk),       64'(send_chunk));
        check_field("send_from_source",     64'(want.send_from_source),
                    64'(send_from_source));
        check_field("send_byte_offset",     64'(want.send_byte_offset),
                    64'(send_byte_offset));
        check_field("send_byte_count",      64'(want.send_byte_count),
                    64'(send_byte_count));
        check_field("send_inline",          64'(want.send_inline),      64'(send_inline));
        check_field("recv_chunk",           64'(want.recv_chunk),       64'(recv_chunk));
        check_field("recv_into_result",     64'(want.recv_into_result),
                    64'(recv_into_result));
        check_field("recv_byte_offset",     64'(want.recv_byte_offset),
                    64'(recv_byte_offset));
        check_field("reduce_active",        64'(want.reduce_active),    64'(reduce_active));
        check_field("reduce_element_count", 64'(want.reduce_element_count),
                    64'(reduce_element_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_plan();
                plans_checked++;
                rx_wait = draw_wait(rx_idle_on);
            end
            // long hold-off on request from the sequence: lets the pipe fill and stall in_ready
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog: any handshake on either channel or the config port counts as progress
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequence helpers
    // ---------------------------------------------------------------------------------
    // APB write: setup, access, done at the edge with pready high. The block reruns its
    // length sequencer afterwards, so wait for in_ready to come back before moving on.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rap_pkg::REG_RING_SIZE:     cfg_ring  = value[6:0];
            rap_pkg::REG_OWN_RANK:      cfg_rank  = value[5:0];
            rap_pkg::REG_ELEMENT_COUNT: cfg_count = value;
            rap_pkg::REG_ELEMENT_BYTES: cfg_bytes = value[3:0];
            default: ;
        endcase
        derive_chunk_lengths();
        repeat (2) @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // narrow registers get junk in the unused upper bits; the block keeps only its width
    task automatic apply_config(input logic [6:0] ring, input logic [5:0] rank,
                                input logic [31:0] count, input logic [3:0] nbytes);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(rap_pkg::REG_RING_SIZE, {junk[31:7], ring});
        junk = $urandom;
        reg_write(rap_pkg::REG_OWN_RANK, {junk[31:6], rank});
        reg_write(rap_pkg::REG_ELEMENT_COUNT, count);
        junk = $urandom;
        reg_write(rap_pkg::REG_ELEMENT_BYTES, {junk[31:4], nbytes});
    endtask

    task automatic queue_step(input logic [6:0] s);
        step_q.push_back(s);
        steps_queued++;
    endtask

    // every request yields exactly one plan, so a count match means the block is idle
    task automatic wait_drained();
        while (plans_checked < steps_queued) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial
    begin
        logic [6:0]      ring;
        logic [5:0]      rank;
        logic [31:0]     count;
        logic [3:0]      nbytes;
        longint unsigned r;
        int              phase;
        int              n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset configuration (R=2), both valid steps, the first bad one and the largest
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        queue_step(7'd0);
        queue_step(7'd1);
        queue_step(7'd2);
        queue_step(7'd127);
        wait_drained();

        // largest ring, top rank, full count, widest elements: offsets near 35-bit top
        apply_config(7'd64, 6'd63, 32'hFFFF_FFFF, 4'd8);
        queue_step(7'd0);
        queue_step(7'd62);
        queue_step(7'd63);
        queue_step(7'd125);
        queue_step(7'd126);
        wait_drained();

        // ring size 0 clamps to 2, rank wraps, zero element size, quotient below 8
        tx_idle_on = 1'b1;
        apply_config(7'd0, 6'd5, 32'd15, 4'd0);
        queue_step(7'd0);
        queue_step(7'd1);
        queue_step(7'd2);
        wait_drained();

        // ring size above the maximum clamps, element size above 8 clamps
        rx_idle_on = 1'b1;
        apply_config(7'd127, 6'd0, 32'd1000, 4'd15);
        queue_step(7'd0);
        queue_step(7'd63);
        queue_step(7'd125);
        queue_step(7'd126);
        wait_drained();

        // small ring walked through both phases, aligned chunk with a longer remainder
        apply_config(7'd3, 6'd1, 32'd50, 4'd1);
        for (n = 0; n < 5; n++) queue_step(n[6:0]);
        wait_drained();

        // ring size 1 clamps to 2, empty vector, element size 9
        apply_config(7'd1, 6'd63, 32'd0, 4'd9);
        queue_step(7'd0);
        queue_step(7'd1);
        wait_drained();

        // random phases: mostly in-range steps, some out of range
        for (phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       ring = 7'($urandom_range(0, 127));
                1:       ring = 7'd64;
                2:       ring = 7'($urandom_range(2, 64));
                default: ring = 7'($urandom_range(2, 12));
            endcase
            rank = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 5))
                0:       count = $urandom;
                1:       count = 32'hFFFF_FFFF;
                2:       count = $urandom_range(0, 15);
                3:       count = $urandom_range(0, 1024);
                default: count = $urandom_range(0, 100000);
            endcase
            nbytes = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            apply_config(ring, rank, count, nbytes);
            r = ring_eff();
            for (n = 0; n < 54; n++)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_step(7'($urandom_range(0, 127)));
                else
                    queue_step(7'($urandom_range(0, 32'(2 * r - 3))));
            end
            // one long receiver stall while the sender keeps offering
            if (phase == 2) holds_asked++;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (plans_due.size() != 0)
        begin
            errors++;
            $display("%0t: plans never delivered, expected 0, actual %0d",
                     $time, plans_due.size());
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> ring_allreduce_chunk_planner_unit.f
sv/rap_pkg.sv
sv/rap_cfg.sv
sv/rap_pipe.sv
sv/ring_allreduce_chunk_planner_unit.sv
bench/tb_ring_allreduce_chunk_planner_unit.sv
